// File: rtl/core/pixel_run_length_encoder_macros.svh
// Assertion macros for the pixel run-length encoder.
// Included by the top level; no other dependencies.
`ifndef PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH
`define PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define PRLE_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define PRLE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define PRLE_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define PRLE_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// File: rtl/core/prle_pkg.sv
// Shared types and constants of the pixel run-length encoder.
// No dependencies; used by every module of the block.
package prle_pkg;

   localparam int MAX_RUN     = 255;
   localparam int WIDTH_LIMIT = 4096;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 8;
   localparam int COL_W       = 12;
   localparam int CSR_W       = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      color_type        color;
      logic             row_end;
   } run_type;

   // Records produced by one item, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      run_type    rec0;
      run_type    rec1;
   } push_type;

endpackage

// File: rtl/core/prle_step.sv
// Run and column tracking: consumes one item per cycle while accept is high and produces
// up to two run records. Depends on prle_pkg.
module prle_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [prle_pkg::CSR_W-1:0]    csr_write_data,
   input  logic                          accept,
   input  prle_pkg::color_type           pixel,
   output prle_pkg::push_type            push
);

   logic [prle_pkg::CSR_W-1:0] row_width_ff;
   prle_pkg::color_type        run_color_ff, run_color_in;
   logic [prle_pkg::LEN_W-1:0] run_count_ff, run_count_in;
   logic [prle_pkg::COL_W-1:0] column_ff, column_in;

   logic [prle_pkg::CSR_W-1:0] eff_width;
   logic [prle_pkg::CSR_W-1:0] column_next;
   logic                       last;
   logic                       emit_change;
   logic                       emit_close;
   prle_pkg::run_type          rec_change;
   prle_pkg::run_type          rec_close;
   prle_pkg::color_type        color_n;
   logic [prle_pkg::LEN_W-1:0] count_n;
   logic                       full;

   always_comb begin
      eff_width = row_width_ff;
      if (row_width_ff == '0) begin
         eff_width = prle_pkg::CSR_W'(1);
      end else if (row_width_ff > prle_pkg::CSR_W'(prle_pkg::WIDTH_LIMIT)) begin
         eff_width = prle_pkg::CSR_W'(prle_pkg::WIDTH_LIMIT);
      end
      column_next = {1'b0, column_ff} + prle_pkg::CSR_W'(1);
      last        = column_next >= eff_width;

      emit_change = 1'b0;
      rec_change  = '{length: run_count_ff, color: run_color_ff, row_end: 1'b0};
      if (run_count_ff == '0) begin
         color_n = pixel;
         count_n = prle_pkg::LEN_W'(1);
      end else if (pixel != run_color_ff) begin
         emit_change = 1'b1;
         color_n     = pixel;
         count_n     = prle_pkg::LEN_W'(1);
      end else begin
         color_n = run_color_ff;
         count_n = run_count_ff + prle_pkg::LEN_W'(1);
      end

      // A full run closes at once; otherwise the row end flushes what is open.
      full       = count_n >= prle_pkg::LEN_W'(prle_pkg::MAX_RUN);
      emit_close = full || last;
      rec_close  = '{length: count_n, color: color_n, row_end: last};

      push.count = {1'b0, emit_change} + {1'b0, emit_close};
      push.rec0  = emit_change ? rec_change : rec_close;
      push.rec1  = rec_close;
      if (!accept) begin
         push.count = '0;
      end

      run_color_in = color_n;
      run_count_in = emit_close ? '0 : count_n;
      column_in    = last ? '0 : column_next[prle_pkg::COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= prle_pkg::CSR_W'(1);
         run_color_ff <= '0;
         run_count_ff <= '0;
         column_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            row_width_ff <= csr_write_data;
         end
         if (accept) begin
            run_color_ff <= run_color_in;
            run_count_ff <= run_count_in;
            column_ff    <= column_in;
         end
      end
   end

endmodule

// File: rtl/core/prle_out_queue.sv
// Result queue: takes up to two run records per cycle and delivers one
// per cycle while pop is high. Depends on prle_pkg.
module prle_out_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  prle_pkg::push_type              push,
   input  logic                            pop,
   output logic                            not_empty,
   output logic                            almost_full,
   output logic [prle_pkg::LEVEL_W-1:0]    level,
   output prle_pkg::run_type               head
);

   prle_pkg::run_type              entry_ff [prle_pkg::QUEUE_DEPTH];
   logic [prle_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [prle_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [prle_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [prle_pkg::PTR_W-1:0]     wr_ptr_plus;

   always_comb begin
      wr_ptr_plus = wr_ptr_ff + prle_pkg::PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + prle_pkg::PTR_W'(push.count);
      rd_ptr_in   = rd_ptr_ff + prle_pkg::PTR_W'(pop);
      level_in    = level_ff + prle_pkg::LEVEL_W'(push.count) - prle_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         entry_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_plus] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Hold off input unless two slots are free.
   assign almost_full = level_ff > prle_pkg::LEVEL_W'(prle_pkg::QUEUE_DEPTH - 2);
   assign not_empty   = level_ff != '0;
   assign level       = level_ff;
   assign head        = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/core/pixel_run_length_encoder.sv
// Pixel run-length encoder: takes one BGR pixel per clock and emits (length, R, G, B, row_end)
// runs. An item is accepted every cycle while the four-entry result queue has two free slots;
// its results show in the next cycle and leave at one per clock while rsp_stall is low.
// A pixel that closes two runs (color change plus full run or row end) pushes two records, so
// a long stream of such pixels is limited by the queue drain of one record per cycle.
// row_width is written via csr_write_enable/csr_write_data; 0 acts as 1, above 4096 as 4096.
`include "pixel_run_length_encoder_macros.svh"
module pixel_run_length_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [prle_pkg::CSR_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prle_pkg::BYTE_W-1:0]       req_pixel_blue,
   input  logic [prle_pkg::BYTE_W-1:0]       req_pixel_green,
   input  logic [prle_pkg::BYTE_W-1:0]       req_pixel_red,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [prle_pkg::LEN_W-1:0]        rsp_run_length,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_run_red,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_run_green,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_run_blue,
   output logic                              rsp_row_end
);

   logic                          req_accept;
   logic                          rsp_accept;
   logic                          almost_full;
   logic [prle_pkg::LEVEL_W-1:0]  level;
   prle_pkg::color_type           pixel;
   prle_pkg::push_type            push;
   prle_pkg::run_type             head;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = almost_full;

   // Swap stored BGR byte order to RGB.
   assign pixel = '{red: req_pixel_red, green: req_pixel_green, blue: req_pixel_blue};

   prle_step u_step (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .pixel            (pixel),
      .push             (push)
   );

   prle_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (rsp_accept),
      .not_empty   (rsp_valid),
      .almost_full (almost_full),
      .level       (level),
      .head        (head)
   );

   assign rsp_run_length = head.length;
   assign rsp_run_red    = head.color.red;
   assign rsp_run_green  = head.color.green;
   assign rsp_run_blue   = head.color.blue;
   assign rsp_row_end    = head.row_end;

   `PRLE_ASSERT_IMPLIES(a_no_push_idle, clock, reset, !req_accept, push.count == 2'd0)
   `PRLE_ASSERT_IMPLIES(a_level_bound, clock, reset, 1'b1, level <= prle_pkg::LEVEL_W'(prle_pkg::QUEUE_DEPTH))
   `PRLE_ASSERT_IMPLIES(a_run_nonzero, clock, reset, rsp_valid, rsp_run_length != '0)
   `PRLE_ASSERT_NEXT(a_push_shows, clock, reset, req_accept && push.count != 2'd0, rsp_valid)

endmodule

// File: tb/sv/pixel_run_length_encoder_checker.sv
// Scoreboard for the pixel run-length encoder: watches the pixel, run and CSR ports,
// predicts the runs of every accepted pixel and compares them in order.
// Depends on prle_pkg only.
module pixel_run_length_encoder_checker
   import prle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [BYTE_W-1:0] req_pixel_blue,
   input  logic [BYTE_W-1:0] req_pixel_green,
   input  logic [BYTE_W-1:0] req_pixel_red,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [LEN_W-1:0]  rsp_run_length,
   input  logic [BYTE_W-1:0] rsp_run_red,
   input  logic [BYTE_W-1:0] rsp_run_green,
   input  logic [BYTE_W-1:0] rsp_run_blue,
   input  logic              rsp_row_end,
   output int                mismatch_count,
   output int                runs_pending,
   output int                runs_checked,
   output int                rows_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 50;

   run_type          expected_runs[$];
   color_type        open_color;
   logic [LEN_W-1:0] open_count;
   logic [COL_W-1:0] column;
   logic [CSR_W-1:0] row_width;

   initial begin
      mismatch_count = 0;
      runs_pending   = 0;
      runs_checked   = 0;
      rows_closed    = 0;
   end

   function automatic int active_width();
      if (row_width == '0) return 1;
      if (row_width > WIDTH_LIMIT) return WIDTH_LIMIT;
      return int'(row_width);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic push_run(input logic [LEN_W-1:0] len, input color_type color,
                           input logic closes_row);
      run_type run;
      run.length  = len;
      run.color   = color;
      run.row_end = closes_row;
      expected_runs.push_back(run);
   endtask

   task automatic encode_pixel(input color_type px);
      logic row_last;
      row_last = (int'(column) + 1 >= active_width());
      if (open_count == '0) begin
         open_color = px;
         open_count = LEN_W'(1);
      end else if (px != open_color) begin
         push_run(open_count, open_color, 1'b0);
         open_color = px;
         open_count = LEN_W'(1);
      end else begin
         open_count = open_count + 1'b1;
      end
      // full run leaves at once; the count restarts empty
      if (open_count >= MAX_RUN) begin
         push_run(open_count, open_color, row_last);
         open_count = '0;
      end
      if (row_last) begin
         if (open_count != '0) push_run(open_count, open_color, 1'b1);
         open_count = '0;
         column     = '0;
      end else begin
         column = column + 1'b1;
      end
   endtask

   task automatic check_run();
      run_type want;
      if (expected_runs.size() == 0) begin
         report_mismatch($sformatf("unexpected run len %0d rgb %02h%02h%02h end %0b",
                                   rsp_run_length, rsp_run_red, rsp_run_green,
                                   rsp_run_blue, rsp_row_end));
         return;
      end
      want = expected_runs.pop_front();
      runs_checked++;
      if (rsp_run_length != want.length)
         report_mismatch($sformatf("run %0d length got %0d want %0d", runs_checked,
                                   rsp_run_length, want.length));
      if (rsp_run_red != want.color.red)
         report_mismatch($sformatf("run %0d red got %02h want %02h", runs_checked,
                                   rsp_run_red, want.color.red));
      if (rsp_run_green != want.color.green)
         report_mismatch($sformatf("run %0d green got %02h want %02h", runs_checked,
                                   rsp_run_green, want.color.green));
      if (rsp_run_blue != want.color.blue)
         report_mismatch($sformatf("run %0d blue got %02h want %02h", runs_checked,
                                   rsp_run_blue, want.color.blue));
      if (rsp_row_end != want.row_end)
         report_mismatch($sformatf("run %0d row_end got %0b want %0b", runs_checked,
                                   rsp_row_end, want.row_end));
      else if (want.row_end)
         rows_closed++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_runs.delete();
         open_color = '0;
         open_count = '0;
         column     = '0;
         row_width  = CSR_W'(1);
      end else begin
         if (csr_write_enable) row_width = csr_write_data;
         if (rsp_valid && !rsp_stall) check_run();
         if (req_valid && !req_stall)
            encode_pixel('{red: req_pixel_red, green: req_pixel_green, blue: req_pixel_blue});
      end
      runs_pending = expected_runs.size();
   end

endmodule

// File: tb/sv/pixel_run_length_encoder_tb.sv
// Top of the pixel run-length encoder bench: clock, reset, pixel stimulus, width writes
// and run-port stall pattern. Depends on prle_pkg, pixel_run_length_encoder and
// pixel_run_length_encoder_checker.
module pixel_run_length_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prle_pkg::*;

   localparam int CYCLE_LIMIT      = 200_000;
   localparam int RANDOM_PIXELS    = 650;
   localparam int SETTLE_CYCLES    = 4;
   localparam int TAIL_CYCLES      = 20;
   localparam int LONG_HOLD_CYCLES = 150;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [CSR_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_pixel_blue = '0;
   logic [BYTE_W-1:0] req_pixel_green = '0;
   logic [BYTE_W-1:0] req_pixel_red = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [LEN_W-1:0]  rsp_run_length;
   logic [BYTE_W-1:0] rsp_run_red;
   logic [BYTE_W-1:0] rsp_run_green;
   logic [BYTE_W-1:0] rsp_run_blue;
   logic              rsp_row_end;

   int        mismatch_count;
   int        runs_pending;
   int        runs_checked;
   int        rows_closed;
   int        cycle_count = 0;
   int        pixels_sent = 0;
   int        width_writes = 0;
   int        burst_left = 0;
   bit        steady_feed = 1'b0;
   bit        start_long_hold = 1'b0;
   bit        long_hold_done = 1'b0;
   color_type prev_color = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pixel_run_length_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_blue   (req_pixel_blue),
      .req_pixel_green  (req_pixel_green),
      .req_pixel_red    (req_pixel_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_red      (rsp_run_red),
      .rsp_run_green    (rsp_run_green),
      .rsp_run_blue     (rsp_run_blue),
      .rsp_row_end      (rsp_row_end)
   );

   pixel_run_length_encoder_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_blue   (req_pixel_blue),
      .req_pixel_green  (req_pixel_green),
      .req_pixel_red    (req_pixel_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_red      (rsp_run_red),
      .rsp_run_green    (rsp_run_green),
      .rsp_run_blue     (rsp_run_blue),
      .rsp_row_end      (rsp_row_end),
      .mismatch_count   (mismatch_count),
      .runs_pending     (runs_pending),
      .runs_checked     (runs_checked),
      .rows_closed      (rows_closed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at cycle %0d with %0d runs outstanding",
                  cycle_count, runs_pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one pixel and hold it until accepted; bursts of random length with gaps.
   task automatic send_pixel(input color_type px);
      int gap;
      if (burst_left == 0) begin
         if (!steady_feed && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_pixel_red   <= px.red;
      req_pixel_green <= px.green;
      req_pixel_blue  <= px.blue;
      do @(posedge clock); while (req_stall);
      prev_color = px;
      pixels_sent++;
   endtask

   // Stop offering until every predicted run has been seen, then let the block settle.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (runs_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_width(input logic [CSR_W-1:0] value);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      width_writes++;
   endtask

   function automatic color_type pick_color(input int repeat_pct);
      int               roll;
      logic [23:0]      bits;
      color_type        c;
      roll = $urandom_range(0, 99);
      if (roll < repeat_pct) begin
         c = prev_color;
      end else if (roll < repeat_pct + (100 - repeat_pct) / 3) begin
         // change a single bit so one byte differs in one bit
         bits = prev_color ^ (24'd1 << $urandom_range(0, 23));
         c = bits;
      end else begin
         bits = 24'($urandom_range(0, 24'hFF_FFFF));
         c = bits;
      end
      return c;
   endfunction

   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             span;
      forever begin
         if (start_long_hold && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(5, 60);
         for (int i = 0; i < span && !(start_long_hold && !long_hold_done); i++) begin
            case (mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
               STALL_PERIODIC: rsp_stall <= (cycle_count % 3 == 0);
               default:        rsp_stall <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      color_type        base;
      logic [CSR_W-1:0] width;
      int               phase;
      int               count;
      int               repeat_pct;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset width: every pixel is a row of its own
      send_pixel('{8'h00, 8'h00, 8'h00});
      send_pixel('{8'hFF, 8'hFF, 8'hFF});
      send_pixel('{8'h00, 8'h00, 8'h00});
      // zero acts as one; checks the byte swap too
      write_row_width('0);
      send_pixel('{8'h56, 8'h34, 8'h12});
      send_pixel('{8'h56, 8'h34, 8'h12});
      // colors that differ in one byte each; last pixel closes two runs
      write_row_width(CSR_W'(4));
      send_pixel('{8'h10, 8'h20, 8'h30});
      send_pixel('{8'h10, 8'h20, 8'h30});
      send_pixel('{8'h11, 8'h20, 8'h30});
      send_pixel('{8'h11, 8'h20, 8'h30});
      send_pixel('{8'h10, 8'h21, 8'h30});
      send_pixel('{8'h10, 8'h20, 8'h31});
      send_pixel('{8'h10, 8'h20, 8'h31});
      send_pixel('{8'h10, 8'h21, 8'h30});
      // shrink the row below the current column
      write_row_width(CSR_W'(8));
      repeat (3) send_pixel('{8'hA5, 8'h5A, 8'hC3});
      write_row_width(CSR_W'(2));
      send_pixel('{8'hA5, 8'h5A, 8'hC3});
      send_pixel('{8'h80, 8'h7F, 8'h80});
      send_pixel('{8'h7F, 8'h80, 8'h7F});
      write_row_width(CSR_W'(WIDTH_LIMIT));
      send_pixel('{8'h01, 8'hFE, 8'h01});
      send_pixel('{8'h01, 8'hFE, 8'h01});
      write_row_width(CSR_W'(1));
      send_pixel('{8'h01, 8'hFE, 8'h01});

      // oversized width: full run mid-row, then the count restarts
      base = pick_color(0);
      write_row_width('1);
      repeat (258) send_pixel(base);
      // close that row early, then a full run that ends exactly on the row end
      write_row_width(CSR_W'(MAX_RUN));
      repeat (MAX_RUN + 1) send_pixel(base);

      phase = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         phase++;
         case ($urandom_range(0, 9))
            0:       width = '0;
            1:       width = CSR_W'(1);
            2:       width = CSR_W'($urandom_range(WIDTH_LIMIT + 1, 8191));
            3:       width = CSR_W'($urandom_range(13, 300));
            default: width = CSR_W'($urandom_range(2, 12));
         endcase
         write_row_width(width);
         case ($urandom_range(0, 3))
            0:       repeat_pct = 0;
            1:       repeat_pct = 40;
            2:       repeat_pct = 75;
            default: repeat_pct = 95;
         endcase
         steady_feed = ($urandom_range(0, 3) == 0);
         count = $urandom_range(4, 40);
         if (phase == 3) begin
            // hold the run port while pixels keep coming so the queue backs up
            steady_feed = 1'b1;
            repeat_pct = 0;
            count = 60;
            start_long_hold = 1'b1;
         end
         for (int n = 0; n < count; n++) begin
            if (phase == 2 && n == count / 2) drain_and_settle();
            send_pixel(pick_color(repeat_pct));
         end
      end
      steady_feed = 1'b0;

      drain_and_settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d pixels over %0d width settings; %0d runs checked, %0d rows closed",
               pixels_sent, width_writes + 1, runs_checked, rows_closed);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/prle_pkg.sv
rtl/core/prle_step.sv
rtl/core/prle_out_queue.sv
rtl/core/pixel_run_length_encoder.sv
tb/sv/pixel_run_length_encoder_checker.sv
tb/sv/pixel_run_length_encoder_tb.sv
